// File: sv/pcrc_pkg.sv
package pcrc_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Longest run of bytes one transaction can cause: length, type and CRC words.
    localparam int RUN_DEPTH = 12;
    localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);

    localparam logic [RUN_CNT_W-1:0] CNT_HEADER   = RUN_CNT_W'(8);
    localparam logic [RUN_CNT_W-1:0] CNT_HDR_CRC  = RUN_CNT_W'(12);
    localparam logic [RUN_CNT_W-1:0] CNT_LAST     = RUN_CNT_W'(5);
    localparam logic [RUN_CNT_W-1:0] CNT_ONE      = RUN_CNT_W'(1);

    typedef logic [7:0] byte_t;

    // One byte of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc_fold8(input logic [31:0] crc, input byte_t data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/png_chunk_crc_framer_unit.sv
// PNG chunk framer with CRC-32.
// Input channel (in_valid / in_ready): opcode 0 opens a chunk with chunk_type and
// chunk_length, opcode 1 carries one payload byte in data_byte.
// Output channel (out_valid / out_ready): one framed byte per transaction. A start
// gives the four length bytes and four type bytes, and the four CRC bytes as well
// when the length is zero. A data byte gives itself, followed by the four CRC bytes
// when it is the last payload byte. run_last marks the last byte caused by an input
// transaction, chunk_end the final CRC byte, misuse a single zero byte for an
// out-of-sequence opcode (state unchanged).
// With the output free, the first byte of an accepted transaction passes from the byte
// sequencer into the output register, from which it is presented to the receiver.
// The framer gives one output byte per cycle while the receiver is ready. A transaction
// causing N bytes occupies the byte sequencer until all N have moved on, so payload bytes
// stream at one per cycle while input and receiver keep up. The next input is accepted
// in the cycle its predecessor's last byte moves into the output register.
// Reset clears the open chunk, the CRC and any bytes not yet delivered.
// When the receiver stalls, the output register holds and the sequencer waits;
// input is held off while the sequencer holds a byte that cannot move on.
module png_chunk_crc_framer_unit
    import pcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] chunk_type,
    input  logic [30:0] chunk_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        chunk_end,
    output logic        misuse
);

    logic [31:0]          crc_reg, crc_next;
    logic [30:0]          left_reg, left_next;
    logic                 open_reg, open_next;

    byte_t                run_reg [RUN_DEPTH];
    byte_t                run_next [RUN_DEPTH];
    logic [RUN_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 rmis_reg, rmis_next;
    logic                 rend_reg, rend_next;

    logic                 ovalid_reg;
    byte_t                obyte_reg;
    logic                 olast_reg, oend_reg, omis_reg;

    logic                 out_load;
    logic                 in_accept;
    logic [31:0]          crc_type;
    logic [31:0]          crc_data;
    logic [30:0]          left_dec;
    logic [95:0]          words;

    assign out_load  = (cnt_reg != '0) && (!ovalid_reg || out_ready);
    assign in_ready  = (cnt_reg == '0) || ((cnt_reg == CNT_ONE) && out_load);
    assign in_accept = in_valid && in_ready;

    assign crc_type = crc_fold8(crc_fold8(crc_fold8(crc_fold8(CRC_INIT, chunk_type[31:24]),
                      chunk_type[23:16]), chunk_type[15:8]), chunk_type[7:0]);
    assign crc_data = crc_fold8(crc_reg, data_byte);
    assign left_dec = left_reg - 31'd1;

    always_comb
    begin
        crc_next  = crc_reg;
        left_next = left_reg;
        open_next = open_reg;
        rmis_next = rmis_reg;
        rend_next = rend_reg;
        cnt_next  = cnt_reg;
        words     = '0;
        for (int i = 0; i < RUN_DEPTH; i++) begin
            run_next[i] = run_reg[i];
        end

        if (out_load) begin
            for (int i = 0; i < RUN_DEPTH - 1; i++) begin
                run_next[i] = run_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_ONE;
        end

        if (in_accept) begin
            rmis_next = 1'b0;
            rend_next = 1'b0;
            if ((opcode == OP_START) == open_reg) begin
                words     = '0;
                cnt_next  = CNT_ONE;
                rmis_next = 1'b1;
            end else if (opcode == OP_START) begin
                words     = {1'b0, chunk_length, chunk_type, ~crc_type};
                crc_next  = crc_type;
                left_next = chunk_length;
                if (chunk_length == '0) begin
                    cnt_next  = CNT_HDR_CRC;
                    rend_next = 1'b1;
                    open_next = 1'b0;
                end else begin
                    cnt_next  = CNT_HEADER;
                    open_next = 1'b1;
                end
            end else begin
                words    = {data_byte, ~crc_data, 56'd0};
                crc_next = crc_data;
                if (left_dec == '0) begin
                    cnt_next  = CNT_LAST;
                    rend_next = 1'b1;
                    open_next = 1'b0;
                    left_next = '0;
                end else begin
                    cnt_next  = CNT_ONE;
                    left_next = left_dec;
                end
            end
            for (int i = 0; i < RUN_DEPTH; i++) begin
                run_next[i] = words[95 - 8 * i -: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg    <= CRC_INIT;
            left_reg   <= '0;
            open_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            left_reg <= left_next;
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            run_reg[i] <= run_next[i];
        end
        rmis_reg <= rmis_next;
        rend_reg <= rend_next;
        if (out_load) begin
            obyte_reg <= run_reg[0];
            olast_reg <= (cnt_reg == CNT_ONE);
            oend_reg  <= (cnt_reg == CNT_ONE) && rend_reg;
            omis_reg  <= rmis_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign run_last  = olast_reg;
    assign chunk_end = oend_reg;
    assign misuse    = omis_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_HDR_CRC)
        else $error("byte sequencer count out of range");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chunk_end) |-> (run_last && !misuse))
        else $error("chunk end not on the last byte of a transaction");

    a_misuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && misuse) |-> (run_last && out_byte == 8'd0))
        else $error("misuse result is not a single zero byte");

    a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (left_reg != '0))
        else $error("open chunk with no payload bytes left");
`endif

endmodule

// File: tb/png_chunk_crc_framer_unit_tb.sv
`timescale 1ns / 100ps

module png_chunk_crc_framer_unit_tb;
    import pcrc_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       chunk_end;
        logic       misuse;
    } frame_byte_t;

    typedef struct packed {
        logic        op;
        logic [31:0] ctype;
        logic [30:0] clen;
        logic [7:0]  dbyte;
        logic        typed;
        frame_byte_t first;
    } stim_row_t;

    typedef enum {RX_FULL, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    localparam int          DIR_ROWS     = 20;
    localparam int          RANDOM_ITEMS = 470;
    localparam logic [30:0] LEN_MAX      = 31'h7FFFFFFF;

    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] TYPE_TEXT = 32'h74455874;

    localparam frame_byte_t MISUSE_BYTE  = {8'h00, 1'b1, 1'b0, 1'b1};
    localparam frame_byte_t ZERO_HEAD    = {8'h00, 1'b0, 1'b0, 1'b0};
    localparam frame_byte_t LEN_MAX_HEAD = {8'h7F, 1'b0, 1'b0, 1'b0};
    localparam frame_byte_t NO_CHECK     = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        chunk_end;
    logic        misuse;

    // Predicted state of the framer.
    logic [31:0] crc_acc;
    logic [30:0] payload_left;
    logic        chunk_is_open;

    frame_byte_t pending_bytes[$];
    frame_byte_t run_bytes[$];
    int          mismatches;
    int          burst_left;
    rx_mode_t    rx_mode = RX_FULL;
    int          rx_cycle = 0;

    // Rows with a typed value pin down the first byte of the run; the rest is predicted.
    stim_row_t dir_tab [DIR_ROWS] = '{
        {OP_DATA,  32'h00000000, 31'd0,   8'h00, 1'b1, MISUSE_BYTE},
        {OP_START, TYPE_IHDR,    31'd0,   8'hFF, 1'b1, ZERO_HEAD},
        {OP_START, 32'hFFFFFFFF, 31'd2,   8'hFF, 1'b1, ZERO_HEAD},
        {OP_START, 32'h00000000, LEN_MAX, 8'h00, 1'b1, MISUSE_BYTE},
        {OP_DATA,  32'hFFFFFFFF, LEN_MAX, 8'h00, 1'b0, NO_CHECK},
        {OP_DATA,  32'hFFFFFFFF, LEN_MAX, 8'hFF, 1'b0, NO_CHECK},
        {OP_DATA,  32'h12345678, 31'd9,   8'hFF, 1'b1, MISUSE_BYTE},
        {OP_START, 32'h00000000, 31'd3,   8'h00, 1'b1, ZERO_HEAD},
        {OP_DATA,  32'h00000000, 31'd0,   8'hA5, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h5A, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h80, 1'b0, NO_CHECK},
        {OP_START, TYPE_IEND,    31'd0,   8'h00, 1'b1, ZERO_HEAD},
        {OP_START, TYPE_IDAT,    31'd1,   8'h00, 1'b0, NO_CHECK},
        {OP_START, 32'h00000000, 31'd0,   8'h00, 1'b1, MISUSE_BYTE},
        {OP_DATA,  32'h00000000, 31'd0,   8'h7F, 1'b0, NO_CHECK},
        {OP_START, TYPE_TEXT,    31'd4,   8'h00, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h01, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h02, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h04, 1'b0, NO_CHECK},
        {OP_DATA,  32'h00000000, 31'd0,   8'h08, 1'b0, NO_CHECK}
    };

    png_chunk_crc_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .chunk_type   (chunk_type),
        .chunk_length (chunk_length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .chunk_end    (chunk_end),
        .misuse       (misuse)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Reflected CRC-32, one data bit per step, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void add_byte(input logic [7:0] v, input logic ce, input logic mis);
        run_bytes.push_back({v, 1'b0, ce, mis});
    endfunction

    function automatic void add_word(input logic [31:0] w);
        for (int s = 24; s >= 0; s -= 8)
            add_byte(w[s +: 8], 1'b0, 1'b0);
    endfunction

    function automatic void add_crc();
        logic [31:0] r;
        r = ~crc_acc;
        add_byte(r[31:24], 1'b0, 1'b0);
        add_byte(r[23:16], 1'b0, 1'b0);
        add_byte(r[15:8], 1'b0, 1'b0);
        add_byte(r[7:0], 1'b1, 1'b0);
        chunk_is_open = 1'b0;
        payload_left = '0;
    endfunction

    // Works out the bytes that one accepted transaction puts on the output stream.
    function automatic void frame_item(input stim_row_t row);
        frame_byte_t tail_b;
        run_bytes.delete();
        if ((row.op == OP_START) == chunk_is_open)
        begin
            add_byte(8'h00, 1'b0, 1'b1);
        end
        else if (row.op == OP_START)
        begin
            add_word({1'b0, row.clen});
            add_word(row.ctype);
            crc_acc = CRC_INIT;
            for (int s = 24; s >= 0; s -= 8)
                crc_acc = crc_byte(crc_acc, row.ctype[s +: 8]);
            chunk_is_open = 1'b1;
            payload_left = row.clen;
            if (row.clen == '0)
                add_crc();
        end
        else
        begin
            add_byte(row.dbyte, 1'b0, 1'b0);
            crc_acc = crc_byte(crc_acc, row.dbyte);
            payload_left = payload_left - 31'd1;
            if (payload_left == '0)
                add_crc();
        end
        tail_b = run_bytes.pop_back();
        tail_b.run_last = 1'b1;
        run_bytes.push_back(tail_b);
    endfunction

    // Called just after a rising edge; returns just after the edge that ends any gap.
    task automatic send_item(input stim_row_t row);
        int gap;
        in_valid     <= 1'b1;
        opcode       <= row.op;
        chunk_type   <= row.ctype;
        chunk_length <= row.clen;
        data_byte    <= row.dbyte;
        do
            @(posedge clk);
        while (!in_ready);
        frame_item(row);
        if (row.typed)
        begin
            void'(run_bytes.pop_front());
            run_bytes.push_front(row.first);
        end
        foreach (run_bytes[i])
            pending_bytes.push_back(run_bytes[i]);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // The receiver switches between stall patterns, holding each for a randomly drawn span.
    always @(posedge clk)
    begin
        if (rx_cycle == 0)
        begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_cycle <= $urandom_range(40, 200);
        end
        else
        begin
            rx_cycle <= rx_cycle - 1;
        end
        case (rx_mode)
            RX_FULL:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ((rx_cycle % 4) == 0);
            default:   out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        frame_byte_t got;
        frame_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_byte, run_last, chunk_end, misuse};
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction: byte=%h last=%b end=%b misuse=%b",
                             got.value, got.run_last, got.chunk_end, got.misuse);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got.value !== want.value || got.run_last !== want.run_last ||
                    got.chunk_end !== want.chunk_end || got.misuse !== want.misuse)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected byte=%h last=%b end=%b misuse=%b,",
                                 want.value, want.run_last, want.chunk_end, want.misuse,
                                 " got byte=%h last=%b end=%b misuse=%b",
                                 got.value, got.run_last, got.chunk_end, got.misuse);
                end
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        int unsigned sent;
        int unsigned pick;
        logic        noise;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_START;
        chunk_type    = '0;
        chunk_length  = '0;
        data_byte     = '0;
        out_ready     = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        crc_acc       = CRC_INIT;
        payload_left  = '0;
        chunk_is_open = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r]);

        // Mostly well-formed chunks, with an out-of-sequence opcode now and then.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            noise     = ($urandom_range(0, 99) < 7);
            row.ctype = $urandom();
            row.clen  = 31'($urandom());
            row.dbyte = 8'($urandom());
            row.typed = 1'b0;
            row.first = NO_CHECK;
            if (chunk_is_open ^ noise)
            begin
                row.op = OP_DATA;
            end
            else
            begin
                row.op = OP_START;
                if ($urandom_range(0, 1) == 1)
                    for (int s = 0; s < 32; s += 8)
                        row.ctype[s +: 8] = 8'($urandom_range(65, 90)) |
                                            (8'($urandom_range(0, 1)) << 5);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    row.clen = 31'($urandom_range(0, 6));
                else if (pick < 95)
                    row.clen = 31'($urandom_range(7, 40));
                else
                    row.clen = 31'($urandom_range(41, 200));
            end
            send_item(row);
            sent++;
        end

        // Close whatever chunk is still open, then open one of the largest length.
        // That chunk can never complete, so it comes last.
        while (chunk_is_open)
            send_item({OP_DATA, 32'($urandom()), 31'($urandom()), 8'($urandom()), 1'b0, NO_CHECK});
        send_item({OP_START, TYPE_IDAT, LEN_MAX, 8'h00, 1'b1, LEN_MAX_HEAD});
        repeat (3)
            send_item({OP_DATA, 32'($urandom()), 31'($urandom()), 8'($urandom()), 1'b0, NO_CHECK});
        send_item({OP_START, TYPE_IEND, 31'd0, 8'h00, 1'b1, MISUSE_BYTE});

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/pcrc_pkg.sv
sv/png_chunk_crc_framer_unit.sv
tb/png_chunk_crc_framer_unit_tb.sv
